### design/matrix_multiply_engine_core_defines.svh
// assertion macros shared by the checker files of the matrix multiply engine
// no dependencies; include by bare file name
`ifndef MATRIX_MULTIPLY_ENGINE_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MME_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define MME_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/mme_pkg.sv
// shared types and constants of the matrix multiply engine
// no dependencies
package mme_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int ACC_BITS       = 40;
    localparam int FRAC_BITS      = 8;
    localparam int DIM_REG_W      = 4;
    localparam int CFG_INDEX_W    = 2;
    localparam logic [DIM_REG_W-1:0] DIM_RESET = DIM_REG_W'(8);

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_A_ROWS    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_B_COLS    = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_OUT
    } state_t;

endpackage

### design/mme_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/matrix_multiply_engine_core.sv
// matrix multiply engine top level: element stores, mac sequencer, output register
// depends on mme_pkg and mme_ram
//
// Usage:
//   s_ channel: s_tuser carries the command, s_tdata the Q8.8 element.
//   load A / load B transactions are taken one per cycle while idle and write
//   the next row-major store position; loads past the end of a store are dropped.
//   a compute transaction drops s_tready until the whole product has gone out.
//   each result element runs inner_dim operand pairs through the shared
//   multiply-accumulate unit and its read, product and accumulate registers,
//   then waits in the output register; the next element starts only after the
//   previous result was taken.
//   m_ channel: m_tdata is the saturated result, m_tlast marks the final
//   element, m_tuser[0] flags saturation. a stalled receiver holds the result
//   and freezes the sequencer.
//   cfg port: write enable, register index, data; write only while idle.
//   reset: dimensions go to 8, both stores read as zero, load positions zero.
module matrix_multiply_engine_core
    import mme_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_REG_W-1:0]   cfg_wdata,
    // input channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,   // element_value
    input  logic [1:0]             s_tuser,   // command
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // out_value
    output logic                   m_tlast,
    output logic [0:0]             m_tuser    // out_saturated
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = $clog2(DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int SH_W   = ACC_BITS - FRAC_BITS;
    localparam longint MAXV = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint MINV = -MAXV - 1;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // configuration
    logic [DIM_REG_W-1:0] a_rows_reg, inner_dim_reg, b_cols_reg;
    logic [DIM_W-1:0]     rows, inner, cols;
    logic [CNT_W-1:0]     rows_m1, inner_m1, cols_m1;

    // sequencer
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [AW-1:0]    a_addr_reg, a_addr_next, b_addr_reg, b_addr_next;
    logic [AW-1:0]    a_base_reg, a_base_next;
    logic [PW-1:0]    a_pos_reg, a_pos_next, b_pos_reg, b_pos_next;
    logic [DEPTH-1:0] a_valid_reg, b_valid_reg;
    logic             a_wr, b_wr, rd_en, acc_clr, out_load, last_elem;

    // mac datapath
    logic [DATA_WIDTH-1:0]        a_rdata, b_rdata;
    logic                         a_vld_reg, b_vld_reg;
    logic                         s1_vld_reg, s2_vld_reg;
    logic signed [DATA_WIDTH-1:0] a_val, b_val;
    logic signed [PROD_W-1:0]     prod_reg;
    logic [ACC_BITS-1:0]          prod_ext;
    logic [ACC_BITS-1:0]          acc_reg;
    logic signed [SH_W-1:0]       shifted;
    logic                         sat_hi, sat_lo;

    // output register
    logic [DATA_WIDTH-1:0] out_value_reg;
    logic                  out_last_reg, out_sat_reg;

    assign rows     = clamp_dim(a_rows_reg);
    assign inner    = clamp_dim(inner_dim_reg);
    assign cols     = clamp_dim(b_cols_reg);
    assign rows_m1  = CNT_W'(rows - DIM_W'(1));
    assign inner_m1 = CNT_W'(inner - DIM_W'(1));
    assign cols_m1  = CNT_W'(cols - DIM_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            b_cols_reg    <= DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_A_ROWS:    a_rows_reg    <= cfg_wdata;
                REG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                REG_B_COLS:    b_cols_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign last_elem = (i_reg == rows_m1) && (j_reg == cols_m1);

    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        a_base_next = a_base_reg;
        a_pos_next  = a_pos_reg;
        b_pos_next  = b_pos_reg;
        a_wr        = 1'b0;
        b_wr        = 1'b0;
        rd_en       = 1'b0;
        acc_clr     = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        CMD_LOAD_A: begin
                            if (a_pos_reg < PW'(DEPTH)) begin
                                a_wr       = 1'b1;
                                a_pos_next = a_pos_reg + PW'(1);
                            end
                        end
                        CMD_LOAD_B: begin
                            if (b_pos_reg < PW'(DEPTH)) begin
                                b_wr       = 1'b1;
                                b_pos_next = b_pos_reg + PW'(1);
                            end
                        end
                        CMD_COMPUTE: begin
                            a_pos_next  = '0;
                            b_pos_next  = '0;
                            i_next      = '0;
                            j_next      = '0;
                            k_next      = '0;
                            a_addr_next = '0;
                            b_addr_next = '0;
                            a_base_next = '0;
                            acc_clr     = 1'b1;
                            state_next  = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                rd_en = 1'b1;
                if (k_reg == inner_m1) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next      = k_reg + CNT_W'(1);
                    a_addr_next = a_addr_reg + AW'(1);
                    b_addr_next = b_addr_reg + AW'(cols);
                end
            end
            ST_DRAIN: begin
                // wait for the last product to land in the accumulator
                if (!s1_vld_reg && !s2_vld_reg) begin
                    out_load   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next  = '0;
                        acc_clr = 1'b1;
                        if (j_reg == cols_m1) begin
                            j_next      = '0;
                            i_next      = i_reg + CNT_W'(1);
                            a_base_next = a_base_reg + AW'(inner);
                            a_addr_next = a_base_reg + AW'(inner);
                            b_addr_next = '0;
                        end else begin
                            j_next      = j_reg + CNT_W'(1);
                            a_addr_next = a_base_reg;
                            b_addr_next = AW'(j_reg) + AW'(1);
                        end
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            a_pos_reg   <= '0;
            b_pos_reg   <= '0;
            a_valid_reg <= '0;
            b_valid_reg <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            a_pos_reg  <= a_pos_next;
            b_pos_reg  <= b_pos_next;
            s1_vld_reg <= rd_en;
            s2_vld_reg <= s1_vld_reg;
            if (a_wr) begin
                a_valid_reg[a_pos_reg[AW-1:0]] <= 1'b1;
            end
            if (b_wr) begin
                b_valid_reg[b_pos_reg[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        a_base_reg <= a_base_next;
    end

    mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_a_ram (
        .clk     (aclk),
        .wr_en   (a_wr),
        .wr_addr (a_pos_reg[AW-1:0]),
        .wr_data (s_tdata[DATA_WIDTH-1:0]),
        .rd_en   (rd_en),
        .rd_addr (a_addr_reg),
        .rd_data (a_rdata)
    );

    mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_b_ram (
        .clk     (aclk),
        .wr_en   (b_wr),
        .wr_addr (b_pos_reg[AW-1:0]),
        .wr_data (s_tdata[DATA_WIDTH-1:0]),
        .rd_en   (rd_en),
        .rd_addr (b_addr_reg),
        .rd_data (b_rdata)
    );

    // never-written entries read as zero
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            a_vld_reg <= a_valid_reg[a_addr_reg];
            b_vld_reg <= b_valid_reg[b_addr_reg];
        end
    end

    assign a_val = a_vld_reg ? $signed(a_rdata) : '0;
    assign b_val = b_vld_reg ? $signed(b_rdata) : '0;

    always_ff @(posedge aclk) begin
        if (s1_vld_reg) begin
            prod_reg <= a_val * b_val;
        end
    end

    generate
        if (PROD_W >= ACC_BITS) begin : g_prod_trunc
            assign prod_ext = prod_reg[ACC_BITS-1:0];
        end else begin : g_prod_sext
            assign prod_ext = {{(ACC_BITS - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (acc_clr) begin
            acc_reg <= '0;
        end else if (s2_vld_reg) begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

    // floor shift then clip to the element range
    assign shifted = $signed(acc_reg[ACC_BITS-1:FRAC_BITS]);
    assign sat_hi  = shifted > $signed(SH_W'(MAXV));
    assign sat_lo  = shifted < $signed(SH_W'(MINV));

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_last_reg <= last_elem;
            out_sat_reg  <= sat_hi || sat_lo;
            if (sat_hi) begin
                out_value_reg <= DATA_WIDTH'(MAXV);
            end else if (sat_lo) begin
                out_value_reg <= DATA_WIDTH'(MINV);
            end else begin
                out_value_reg <= shifted[DATA_WIDTH-1:0];
            end
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = (state_reg == ST_OUT);
    assign m_tdata    = TDATA_W'(out_value_reg);
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_sat_reg;

endmodule

### design/mme_checker.sv
// port-level checker for the matrix multiply engine, bound to the top level
// depends on mme_pkg and matrix_multiply_engine_core_defines.svh
`include "matrix_multiply_engine_core_defines.svh"

module mme_checker
    import mme_pkg::*;
#(
    parameter int TDATA_W = 16
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_wr_en,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [DIM_REG_W-1:0]   cfg_wdata,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [TDATA_W-1:0]     s_tdata,
    input logic [1:0]             s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_W-1:0]     m_tdata,
    input logic                   m_tlast,
    input logic [0:0]             m_tuser
);

    logic s_xfer, m_xfer;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    // no input is taken while a result is pending
    `MME_ASSERT_NOW(a_busy_while_out, aclk, aresetn, m_tvalid, !s_tready)

    // a stalled result holds its payload
    `MME_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // a load leaves the block ready in the next cycle, with no result pending
    `MME_ASSERT_NEXT(a_load_one_cycle, aclk, aresetn, s_xfer && (s_tuser != CMD_COMPUTE),
        s_tready && !m_tvalid)

    // a compute transaction starts the multiply-accumulate, no result yet
    `MME_ASSERT_NEXT(a_compute_busy, aclk, aresetn, s_xfer && (s_tuser == CMD_COMPUTE),
        !s_tready && !m_tvalid)

    // the final result returns the block to idle
    `MME_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, m_xfer && m_tlast,
        s_tready && !m_tvalid)

endmodule

bind matrix_multiply_engine_core mme_checker #(.TDATA_W(TDATA_W)) u_mme_checker (.*);
